### hdl/cbad_pkg.sv
// ----------------------------------------------------------------------------
// Console bus address decoder package
// Sizes, address constants, access codes and shared types of the decoder.
// ----------------------------------------------------------------------------
package cbad_pkg;

  localparam int RAM_BYTES     = 2097152;
  localparam int SCRATCH_BYTES = 1024;
  localparam int ROM_BYTES     = 524288;

  localparam int RAM_WORDS     = (RAM_BYTES + 3) / 4;
  localparam int SCRATCH_WORDS = (SCRATCH_BYTES + 3) / 4;
  localparam int ROM_WORDS     = (ROM_BYTES + 3) / 4;
  localparam int MEMCTL_WORDS  = 4;

  localparam int RAM_AW = $clog2(RAM_WORDS);
  localparam int SCR_AW = $clog2(SCRATCH_WORDS);
  localparam int ROM_AW = $clog2(ROM_WORDS);
  localparam int ROM_OB = $clog2(ROM_BYTES);

  // Boot ROM offsets are reduced modulo ROM_BYTES by one compare and subtract
  // per cycle when ROM_BYTES is not a power of two.
  localparam bit          ROM_POW2     = (ROM_BYTES & (ROM_BYTES - 1)) == 0;
  localparam int          ROM_STEPS    = 33 - ROM_OB;
  localparam int          RED_CW       = $clog2(ROM_STEPS);
  localparam logic [32:0] ROM_DSH_INIT = 33'(ROM_BYTES) << (ROM_STEPS - 1);
  localparam logic [31:0] ROM_MASK     = 32'(ROM_BYTES - 1);

  localparam logic [RAM_AW-1:0] CLR_LAST = RAM_AW'(RAM_WORDS - 1);

  localparam logic [2:0]  SEG_KSEG0       = 3'd4;
  localparam logic [2:0]  SEG_KSEG1       = 3'd5;
  localparam logic [31:0] SEG4_MASK       = 32'h7FFF_FFFF;
  localparam logic [31:0] SEG5_MASK       = 32'h1FFF_FFFF;
  localparam logic [31:0] ROM_WRAP        = 32'h0007_FFFF;
  localparam logic [31:0] TIMER_STUB      = 32'h0000_16B0;
  localparam logic [31:0] RAM_SIZE_ADDR   = 32'h1F80_1060;
  localparam logic [31:0] DMA_BASE        = 32'h1F80_1080;
  localparam logic [31:0] CACHE_CTRL_ADDR = 32'hFFFE_0130;

  localparam logic [1:0] CMD_READ     = 2'd0;
  localparam logic [1:0] CMD_WRITE    = 2'd1;
  localparam logic [1:0] CMD_ROM_LOAD = 2'd2;
  localparam logic [1:0] CMD_RESERVED = 2'd3;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;
  localparam logic [1:0] SIZE_BAD  = 2'd3;

  localparam logic [2:0] STATUS_OK          = 3'd0;
  localparam logic [2:0] STATUS_MISALIGN_LD = 3'd1;
  localparam logic [2:0] STATUS_MISALIGN_ST = 3'd2;
  localparam logic [2:0] STATUS_UNMAPPED    = 3'd3;
  localparam logic [2:0] STATUS_BAD_SIZE    = 3'd4;

  localparam logic [2:0] TGT_LOCAL = 3'd0;
  localparam logic [2:0] TGT_IRQ   = 3'd1;
  localparam logic [2:0] TGT_DMA   = 3'd2;
  localparam logic [2:0] TGT_CD    = 3'd3;
  localparam logic [2:0] TGT_SPU   = 3'd4;
  localparam logic [2:0] TGT_GPU   = 3'd5;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_ROMRD,
    ST_ACCESS
  } state_t;

  typedef enum logic [2:0] {
    RG_NONE,
    RG_MAIN,
    RG_SCRATCH,
    RG_MEMCTL,
    RG_ROM_RD,
    RG_ROM_LOAD,
    RG_RAM_SIZE,
    RG_CACHE
  } region_t;

  typedef struct packed {
    region_t     region;
    logic [2:0]  status;
    logic [2:0]  target;
    logic [31:0] stub;
    logic [31:0] phys;
  } dec_t;

endpackage

### hdl/cbad_if.sv
// ----------------------------------------------------------------------------
// Console bus address decoder channels
// Request and response channels with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface cbad_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] address;
  logic [1:0]  size;
  logic [31:0] write_data;

  modport source (output valid, command, address, size, write_data, input ready);
  modport sink (input valid, command, address, size, write_data, output ready);
endinterface

interface cbad_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic [2:0]  status;
  logic [2:0]  target;
  logic [31:0] phys_address;

  modport source (output valid, read_data, status, target, phys_address, input ready);
  modport sink (input valid, read_data, status, target, phys_address, output ready);
endinterface

### hdl/console_bus_address_decoder_core.sv
// ----------------------------------------------------------------------------
// Console bus address decoder core
// Decodes one bus access, serves the local memories and registers, and
// names the target unit for forwarded accesses.
// ----------------------------------------------------------------------------
//  Port  Dir   Payload                                    Transfer
//  req   sink  command, address, size, write_data         valid && ready
//  rsp   src   read_data, status, target, phys_address    valid && ready
//
// One access is in flight at a time. Main RAM, scratchpad, register and
// forwarded accesses go through decode and RAM read, then modify, write
// back and load the output register. Boot ROM reads add a ROM read step
// before the access step; when ROM_BYTES is not a power of two, ROM reads
// and loads first pass through the reduce state. After reset, a clearing
// pass zeroes main RAM and scratchpad while req.ready stays low. The access
// step waits while the output register holds a result not yet taken.
// ----------------------------------------------------------------------------
module console_bus_address_decoder_core (
  input logic       clk,
  input logic       rst,
  cbad_req_if.sink  req,
  cbad_rsp_if.source rsp
);

  function automatic logic [31:0] width_mask(input logic [1:0] sz);
    logic [31:0] m;
    case (sz)
      cbad_pkg::SIZE_BYTE: m = 32'h0000_00FF;
      cbad_pkg::SIZE_HALF: m = 32'h0000_FFFF;
      default:             m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic [11:0] scr_mod(input logic [9:0] x);
    logic [15:0] r;
    r = {6'd0, x};
    for (int k = 2; k >= 0; k--) begin
      if (r >= 16'(cbad_pkg::SCRATCH_BYTES << k)) begin
        r = r - 16'(cbad_pkg::SCRATCH_BYTES << k);
      end
    end
    return r[11:0];
  endfunction

  function automatic cbad_pkg::dec_t decode(input logic [1:0] cmd, input logic [31:0] va,
                                            input logic [1:0] sz);
    cbad_pkg::dec_t d;
    logic [31:0]    p;
    logic [31:0]    wm;
    logic           wr;
    wr = (cmd == cbad_pkg::CMD_WRITE);
    wm = width_mask(sz);
    unique case (va[31:29])
      cbad_pkg::SEG_KSEG0: p = va & cbad_pkg::SEG4_MASK;
      cbad_pkg::SEG_KSEG1: p = va & cbad_pkg::SEG5_MASK;
      default:             p = va;
    endcase
    d.region = cbad_pkg::RG_NONE;
    d.status = cbad_pkg::STATUS_OK;
    d.target = cbad_pkg::TGT_LOCAL;
    d.stub   = '0;
    d.phys   = p;
    if (cmd == cbad_pkg::CMD_ROM_LOAD) begin
      d.region = cbad_pkg::RG_ROM_LOAD;
    end else if (cmd == cbad_pkg::CMD_RESERVED) begin
      d.status = cbad_pkg::STATUS_UNMAPPED;
    end else if (sz == cbad_pkg::SIZE_BAD) begin
      d.status = cbad_pkg::STATUS_BAD_SIZE;
    end else if ((sz == cbad_pkg::SIZE_HALF && p[0]) ||
                 (sz == cbad_pkg::SIZE_WORD && p[1:0] != 2'd0)) begin
      d.status = wr ? cbad_pkg::STATUS_MISALIGN_ST : cbad_pkg::STATUS_MISALIGN_LD;
    end else if (p < 32'(cbad_pkg::RAM_BYTES)) begin
      d.region = cbad_pkg::RG_MAIN;
    end else if (p >= 32'h1F00_0000 && p <= 32'h1F3F_FFFF) begin
      d.stub = wr ? 32'd0 : (32'hFF & wm);
    end else if (p >= 32'h1F80_0000 && p <= 32'h1F80_03FF) begin
      d.region = cbad_pkg::RG_SCRATCH;
    end else if (p >= 32'h1F80_0400 && p <= 32'h1F80_103F) begin
      d.region = cbad_pkg::RG_MEMCTL;
    end else if (p == 32'h1F80_1040) begin
      d.stub = wr ? 32'd0 : (32'hFF & wm);
    end else if (p == 32'h1F80_1044 && !wr) begin
      d.stub = 32'd7 & wm;
    end else if (p == 32'h1F80_104A) begin
      d.stub = '0;
    end else if ((p == 32'h1F80_1048 || p == 32'h1F80_104E) && wr) begin
      d.stub = '0;
    end else if (p == cbad_pkg::RAM_SIZE_ADDR) begin
      d.region = cbad_pkg::RG_RAM_SIZE;
    end else if (p >= 32'h1F80_1070 && p <= 32'h1F80_1078) begin
      d.target = cbad_pkg::TGT_IRQ;
    end else if (p >= cbad_pkg::DMA_BASE && p <= 32'h1F80_10FF) begin
      d.target = cbad_pkg::TGT_DMA;
    end else if (p >= 32'h1F80_1100 && p <= 32'h1F80_1130 &&
                 (!wr || p <= 32'h1F80_112F)) begin
      d.stub = (!wr && p == 32'h1F80_1120) ? (cbad_pkg::TIMER_STUB & wm) : 32'd0;
    end else if (p >= 32'h1F80_1800 && p <= 32'h1F80_1803) begin
      d.target = cbad_pkg::TGT_CD;
    end else if (p >= 32'h1F80_1810 && p <= 32'h1F80_1817 &&
                 (p[3:0] == 4'h0 || p[3:0] == 4'h4)) begin
      d.target = cbad_pkg::TGT_GPU;
    end else if (p >= 32'h1F80_1C00 && p <= 32'h1F80_1FFF) begin
      d.target = cbad_pkg::TGT_SPU;
    end else if (p >= 32'h1F80_2000 && p <= 32'h1F80_3FFF) begin
      d.stub = '0;
    end else if (p >= 32'h1FC0_0000 && p <= 32'h1FC7_FFFF && !wr) begin
      d.region = cbad_pkg::RG_ROM_RD;
    end else if (p == cbad_pkg::CACHE_CTRL_ADDR) begin
      d.region = cbad_pkg::RG_CACHE;
    end else begin
      d.status = cbad_pkg::STATUS_UNMAPPED;
    end
    return d;
  endfunction

  cbad_pkg::state_t state;
  cbad_pkg::state_t state_next;

  cbad_pkg::dec_t dec;
  logic [11:0]    scr_off_in;
  logic [31:0]    rom_x;
  logic           rom_op;

  cbad_pkg::dec_t acc;
  logic           acc_wr;
  logic [1:0]     acc_size;
  logic [31:0]    acc_wdata;
  logic [11:0]    acc_scr_off;

  logic [31:0]               red;
  logic [32:0]               dsh;
  logic [cbad_pkg::RED_CW-1:0] red_cnt;

  logic [cbad_pkg::RAM_AW-1:0] clr_cnt;
  logic [31:0] memctl [cbad_pkg::MEMCTL_WORDS];
  logic [31:0] ram_size_reg;
  logic [31:0] cache_ctrl_reg;

  logic        out_valid;
  logic [31:0] out_read_data;
  logic [2:0]  out_status;
  logic [2:0]  out_target;
  logic [31:0] out_phys;
  logic        out_free;

  logic ld_acc;
  logic ld_out;

  logic                        main_we;
  logic                        main_re;
  logic [cbad_pkg::RAM_AW-1:0] main_waddr;
  logic [31:0]                 main_wdata;
  logic [31:0]                 main_rdata;
  logic                        scr_we;
  logic                        scr_re;
  logic [cbad_pkg::SCR_AW-1:0] scr_waddr;
  logic [31:0]                 scr_wdata;
  logic [31:0]                 scr_rdata;
  logic                        rom_we;
  logic                        rom_re;
  logic [31:0]                 rom_rdata;

  logic [31:0] old_word;
  logic [1:0]  lane;
  logic [4:0]  sh;
  logic [31:0] wm;
  logic [31:0] lmask;
  logic [31:0] merged;
  logic [31:0] lane_rd;
  logic [31:0] rd_next;
  logic [31:0] phys_next;

  assign dec        = decode(req.command, req.address, req.size);
  assign scr_off_in = scr_mod(dec.phys[9:0]);
  assign rom_x      = (req.command == cbad_pkg::CMD_ROM_LOAD) ? req.address
                                                             : (dec.phys & cbad_pkg::ROM_WRAP);
  assign rom_op     = (dec.region == cbad_pkg::RG_ROM_LOAD) ||
                      (dec.region == cbad_pkg::RG_ROM_RD);
  assign out_free   = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cbad_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    ld_acc     = 1'b0;
    ld_out     = 1'b0;
    main_re    = 1'b0;
    scr_re     = 1'b0;
    rom_re     = 1'b0;
    main_we    = 1'b0;
    scr_we     = 1'b0;
    rom_we     = 1'b0;
    unique case (state)
      cbad_pkg::ST_CLEAR: begin
        main_we = 1'b1;
        scr_we  = 32'(clr_cnt) < 32'(cbad_pkg::SCRATCH_WORDS);
        if (clr_cnt == cbad_pkg::CLR_LAST) begin
          state_next = cbad_pkg::ST_IDLE;
        end
      end
      cbad_pkg::ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          ld_acc  = 1'b1;
          main_re = dec.region == cbad_pkg::RG_MAIN;
          scr_re  = dec.region == cbad_pkg::RG_SCRATCH;
          if (rom_op && !cbad_pkg::ROM_POW2) begin
            state_next = cbad_pkg::ST_REDUCE;
          end else if (dec.region == cbad_pkg::RG_ROM_RD) begin
            state_next = cbad_pkg::ST_ROMRD;
          end else begin
            state_next = cbad_pkg::ST_ACCESS;
          end
        end
      end
      cbad_pkg::ST_REDUCE: begin
        if (red_cnt == '0) begin
          state_next = (acc.region == cbad_pkg::RG_ROM_RD) ? cbad_pkg::ST_ROMRD
                                                           : cbad_pkg::ST_ACCESS;
        end
      end
      cbad_pkg::ST_ROMRD: begin
        rom_re     = 1'b1;
        state_next = cbad_pkg::ST_ACCESS;
      end
      cbad_pkg::ST_ACCESS: begin
        if (out_free) begin
          ld_out     = 1'b1;
          main_we    = acc.region == cbad_pkg::RG_MAIN && acc_wr;
          scr_we     = acc.region == cbad_pkg::RG_SCRATCH && acc_wr;
          rom_we     = acc.region == cbad_pkg::RG_ROM_LOAD;
          state_next = cbad_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cbad_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    old_word = '0;
    lane     = acc.phys[1:0];
    case (acc.region)
      cbad_pkg::RG_MAIN:     old_word = main_rdata;
      cbad_pkg::RG_SCRATCH: begin
        old_word = scr_rdata;
        lane     = acc_scr_off[1:0];
      end
      cbad_pkg::RG_MEMCTL:   old_word = memctl[acc.phys[3:2]];
      cbad_pkg::RG_ROM_RD: begin
        old_word = rom_rdata;
        lane     = red[1:0];
      end
      cbad_pkg::RG_RAM_SIZE: old_word = ram_size_reg;
      cbad_pkg::RG_CACHE:    old_word = cache_ctrl_reg;
      default:               old_word = '0;
    endcase
    sh      = {lane, 3'b000};
    wm      = width_mask(acc_size);
    lmask   = wm << sh;
    merged  = (old_word & ~lmask) | ((acc_wdata << sh) & lmask);
    lane_rd = (old_word & lmask) >> sh;
    case (acc.region)
      cbad_pkg::RG_NONE:     rd_next = acc.stub;
      cbad_pkg::RG_ROM_LOAD: rd_next = '0;
      default:               rd_next = acc_wr ? 32'd0 : lane_rd;
    endcase
    phys_next = (acc.region == cbad_pkg::RG_ROM_LOAD) ? {red[31:2], 2'b00} : acc.phys;
  end

  // The read of an entry is issued only at acceptance and its write-back
  // only in the access step, so the ports never touch one entry together.
  always_comb begin
    main_waddr = acc.phys[cbad_pkg::RAM_AW+1:2];
    main_wdata = merged;
    scr_waddr  = acc_scr_off[cbad_pkg::SCR_AW+1:2];
    scr_wdata  = merged;
    if (state == cbad_pkg::ST_CLEAR) begin
      main_waddr = clr_cnt;
      main_wdata = '0;
      scr_waddr  = clr_cnt[cbad_pkg::SCR_AW-1:0];
      scr_wdata  = '0;
    end
  end

  cbad_ram #(
    .WIDTH(32),
    .DEPTH(cbad_pkg::RAM_WORDS)
  ) u_main_ram (
    .clk  (clk),
    .we   (main_we),
    .waddr(main_waddr),
    .wdata(main_wdata),
    .re   (main_re),
    .raddr(dec.phys[cbad_pkg::RAM_AW+1:2]),
    .rdata(main_rdata)
  );

  cbad_ram #(
    .WIDTH(32),
    .DEPTH(cbad_pkg::SCRATCH_WORDS)
  ) u_scratch_ram (
    .clk  (clk),
    .we   (scr_we),
    .waddr(scr_waddr),
    .wdata(scr_wdata),
    .re   (scr_re),
    .raddr(scr_off_in[cbad_pkg::SCR_AW+1:2]),
    .rdata(scr_rdata)
  );

  cbad_ram #(
    .WIDTH(32),
    .DEPTH(cbad_pkg::ROM_WORDS)
  ) u_boot_rom (
    .clk  (clk),
    .we   (rom_we),
    .waddr(red[cbad_pkg::ROM_AW+1:2]),
    .wdata(acc_wdata),
    .re   (rom_re),
    .raddr(red[cbad_pkg::ROM_AW+1:2]),
    .rdata(rom_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == cbad_pkg::ST_CLEAR && clr_cnt != cbad_pkg::CLR_LAST) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (ld_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ram_size_reg   <= '0;
      cache_ctrl_reg <= '0;
      memctl         <= '{default: '0};
    end else if (ld_out && acc_wr) begin
      if (acc.region == cbad_pkg::RG_RAM_SIZE) begin
        ram_size_reg <= acc_wdata & wm;
      end
      if (acc.region == cbad_pkg::RG_CACHE) begin
        cache_ctrl_reg <= acc_wdata & wm;
      end
      if (acc.region == cbad_pkg::RG_MEMCTL) begin
        memctl[acc.phys[3:2]] <= merged;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_acc) begin
      acc         <= dec;
      acc_wr      <= req.command == cbad_pkg::CMD_WRITE;
      acc_size    <= req.size;
      acc_wdata   <= req.write_data;
      acc_scr_off <= scr_off_in;
      red         <= cbad_pkg::ROM_POW2 ? (rom_x & cbad_pkg::ROM_MASK) : rom_x;
      dsh         <= cbad_pkg::ROM_DSH_INIT;
      red_cnt     <= cbad_pkg::RED_CW'(cbad_pkg::ROM_STEPS - 1);
    end else if (state == cbad_pkg::ST_REDUCE) begin
      if ({1'b0, red} >= dsh) begin
        red <= red - dsh[31:0];
      end
      dsh     <= dsh >> 1;
      red_cnt <= red_cnt - cbad_pkg::RED_CW'(1);
    end
    if (ld_out) begin
      out_read_data <= rd_next;
      out_status    <= acc.status;
      out_target    <= acc.target;
      out_phys      <= phys_next;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.read_data    = out_read_data;
  assign rsp.status       = out_status;
  assign rsp.target       = out_target;
  assign rsp.phys_address = out_phys;

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted while an access was in flight");

  a_error_quiet: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != cbad_pkg::STATUS_OK |->
      rsp.target == cbad_pkg::TGT_LOCAL && rsp.read_data == '0)
    else $error("failed access returned data or a target");

  a_forward_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.target != cbad_pkg::TGT_LOCAL |-> rsp.read_data == '0)
    else $error("forwarded access returned local data");

  a_rom_offset: assert property (@(posedge clk) disable iff (rst)
    ld_out && acc.region == cbad_pkg::RG_ROM_LOAD |=>
      rsp.phys_address[1:0] == 2'b00 && rsp.phys_address < 32'(cbad_pkg::ROM_BYTES))
    else $error("boot ROM load offset not reduced to a word in range");

  a_clear_done: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> clr_cnt == cbad_pkg::CLR_LAST)
    else $error("request taken before the clearing pass finished");

endmodule

### hdl/cbad_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cbad_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
